// ===== rtl/core/xcr_pkg.sv =====
// Package for the XMODEM-CRC receiver: payload structs, protocol codes,
// phase and status codes and the CRC byte step. No dependencies.
package xcr_pkg;

   localparam int LongBlockBytes  = 1024;
   localparam int ShortBlockBytes = 128;
   localparam int QueueDepth      = 2;

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_LCAN  = 2'd3;

   localparam logic [1:0] CSR_RETRY = 2'd0;
   localparam logic [1:0] CSR_HDR   = 2'd1;
   localparam logic [1:0] CSR_CHAR  = 2'd2;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_HDR  = 3'd1;
   localparam logic [2:0] PH_BNO  = 3'd2;
   localparam logic [2:0] PH_BINV = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_CHI  = 3'd5;
   localparam logic [2:0] PH_CLO  = 3'd6;
   localparam logic [2:0] PH_DONE = 3'd7;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_OK    = 3'd2;
   localparam logic [2:0] ST_RCAN  = 3'd3;
   localparam logic [2:0] ST_TMO   = 3'd4;
   localparam logic [2:0] ST_ORDER = 3'd5;
   localparam logic [2:0] ST_LCAN  = 3'd6;

   localparam logic [1:0] VD_NONE    = 2'd0;
   localparam logic [1:0] VD_ACCEPT  = 2'd1;
   localparam logic [1:0] VD_DISCARD = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [1:0]  block_verdict;
      logic [2:0]  session_status;
      logic [31:0] bytes_received;
      logic        last;
   } rsp_type;

   // Configuration snapshot handed from the register block to the engine.
   typedef struct packed {
      logic [7:0]  retry_limit;
      logic [16:0] header_timeout_ticks;
      logic [16:0] char_timeout_ticks;
   } cfg_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/xcr_front.sv =====
// Front end of the XMODEM-CRC receiver: accepts request transfers and
// holds them in a short queue for the engine. Uses xcr_pkg.
module xcr_front #(
   parameter int Depth = xcr_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xcr_pkg::req_type req_data,
   output logic             q_valid,
   input  logic             q_take,
   output xcr_pkg::req_type q_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   xcr_pkg::req_type mem_ff [Depth];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == (AW+1)'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_valid && q_take;
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ((wr_ff == AW'(Depth-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? ((rd_ff == AW'(Depth-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= req_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(Depth))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
                    (cnt_ff == '0) |-> !pop)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
                    push && !pop |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count missed a push");
endmodule

// ===== rtl/core/xcr_engine.sv =====
// Protocol engine of the XMODEM-CRC receiver: phase machine, CRC, timers,
// and a two-entry result buffer toward the response port. Uses xcr_pkg.
module xcr_engine #(
   parameter int LongBytes  = xcr_pkg::LongBlockBytes,
   parameter int ShortBytes = xcr_pkg::ShortBlockBytes
) (
   input  logic             clock,
   input  logic             reset,
   input  xcr_pkg::cfg_type cfg,
   input  logic             q_valid,
   output logic             q_take,
   input  xcr_pkg::req_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xcr_pkg::rsp_type rsp_data
);
   localparam logic [9:0] LongLast  = 10'(LongBytes - 1);
   localparam logic [9:0] ShortLast = 10'(ShortBytes - 1);

   logic [2:0]  phase_ff, phase_in;
   logic        first_ff, first_in;
   logic [7:0]  retry_ff, retry_in;
   logic [7:0]  exp_ff, exp_in;
   logic [7:0]  bno_ff, bno_in;
   logic [7:0]  binv_ff, binv_in;
   logic        long_ff, long_in;
   logic [9:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  chi_ff, chi_in;
   logic [16:0] wait_ff, wait_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  st_ff, st_in;

   // Result buffer: slot 0 is shown, slot 1 holds the second result.
   xcr_pkg::rsp_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic [1:0] cnt_ff, cnt_in;

   xcr_pkg::rsp_type r0, r1;
   logic       two;
   logic [1:0] sv;
   logic [7:0] b;
   logic [16:0] wt;
   logic [32:0] accsum;
   logic        popped;

   assign popped    = rsp_valid && !rsp_stall;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot0_ff;
   // Take an item when the buffer will be empty after this cycle.
   assign q_take    = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && popped);

   always_comb begin
      phase_in = phase_ff; first_in = first_ff; retry_in = retry_ff;
      exp_in = exp_ff; bno_in = bno_ff; binv_in = binv_ff; long_in = long_ff;
      idx_in = idx_ff; crc_in = crc_ff; chi_in = chi_ff; wait_in = wait_ff;
      acc_in = acc_ff; st_in = st_ff;
      r0 = '0; r1 = '0; two = 1'b0;
      b = q_data.rx_byte;
      wt = '0;
      accsum = {1'b0, acc_ff} + (long_ff ? 33'(LongBytes) : 33'(ShortBytes));
      sv = ((phase_ff == xcr_pkg::PH_DATA && idx_ff != '0) ||
            phase_ff == xcr_pkg::PH_CHI || phase_ff == xcr_pkg::PH_CLO)
           ? xcr_pkg::VD_DISCARD : xcr_pkg::VD_NONE;
      case (q_data.op)
         xcr_pkg::OP_START: begin
            phase_in = xcr_pkg::PH_HDR; first_in = 1'b0; retry_in = '0;
            exp_in = 8'd1; idx_in = '0; crc_in = '0; wait_in = '0; acc_in = '0;
            st_in = xcr_pkg::ST_RUN;
            r0.tx_valid = 1'b1; r0.tx_byte = xcr_pkg::B_C; r0.block_verdict = sv;
         end
         xcr_pkg::OP_BYTE: begin
            wait_in = '0;
            case (phase_ff)
               xcr_pkg::PH_HDR: begin
                  retry_in = '0;
                  if (b == xcr_pkg::B_EOT) begin
                     r0.tx_valid = 1'b1; r0.tx_byte = xcr_pkg::B_ACK;
                     st_in = xcr_pkg::ST_OK; phase_in = xcr_pkg::PH_DONE;
                  end else if (b == xcr_pkg::B_CAN) begin
                     st_in = xcr_pkg::ST_RCAN; phase_in = xcr_pkg::PH_DONE;
                  end else if (b == xcr_pkg::B_SOH || b == xcr_pkg::B_STX) begin
                     long_in = (b == xcr_pkg::B_STX); first_in = 1'b1;
                     phase_in = xcr_pkg::PH_BNO;
                  end else begin
                     r0.tx_valid = 1'b1; r0.tx_byte = xcr_pkg::B_NAK;
                     if (!first_ff) begin
                        two = 1'b1; r1.tx_valid = 1'b1; r1.tx_byte = xcr_pkg::B_C;
                     end
                  end
               end
               xcr_pkg::PH_BNO: begin
                  bno_in = b; phase_in = xcr_pkg::PH_BINV;
               end
               xcr_pkg::PH_BINV: begin
                  binv_in = b; idx_in = '0; crc_in = '0; phase_in = xcr_pkg::PH_DATA;
               end
               xcr_pkg::PH_DATA: begin
                  crc_in = xcr_pkg::crc_step(crc_ff, b);
                  r0.data_valid = 1'b1; r0.data_byte = b;
                  if (idx_ff == (long_ff ? LongLast : ShortLast)) begin
                     idx_in = '0; phase_in = xcr_pkg::PH_CHI;
                  end else begin
                     idx_in = idx_ff + 10'd1;
                  end
               end
               xcr_pkg::PH_CHI: begin
                  chi_in = b; phase_in = xcr_pkg::PH_CLO;
               end
               xcr_pkg::PH_CLO: begin
                  phase_in = xcr_pkg::PH_HDR;
                  r0.tx_valid = 1'b1;
                  if (8'(bno_ff + binv_ff) != 8'hFF || {chi_ff, b} != crc_ff) begin
                     r0.tx_byte = xcr_pkg::B_NAK; r0.block_verdict = xcr_pkg::VD_DISCARD;
                  end else if (bno_ff == exp_ff) begin
                     acc_in = accsum[32] ? 32'hFFFF_FFFF : accsum[31:0];
                     exp_in = exp_ff + 8'd1;
                     r0.tx_byte = xcr_pkg::B_ACK; r0.block_verdict = xcr_pkg::VD_ACCEPT;
                  end else if (bno_ff == 8'(exp_ff - 8'd1)) begin
                     r0.tx_byte = xcr_pkg::B_ACK; r0.block_verdict = xcr_pkg::VD_DISCARD;
                  end else begin
                     r0.tx_byte = xcr_pkg::B_CAN; r0.block_verdict = xcr_pkg::VD_DISCARD;
                     st_in = xcr_pkg::ST_ORDER; phase_in = xcr_pkg::PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
         xcr_pkg::OP_TICK: begin
            if (phase_ff != xcr_pkg::PH_IDLE && phase_ff != xcr_pkg::PH_DONE) begin
               wt = (wait_ff == 17'h1FFFF) ? wait_ff : wait_ff + 17'd1;
               wait_in = wt;
               if (phase_ff == xcr_pkg::PH_HDR) begin
                  if (wt >= cfg.header_timeout_ticks) begin
                     retry_in = retry_ff + 8'd1; wait_in = '0;
                     r0.tx_valid = 1'b1;
                     if (retry_ff + 8'd1 >= cfg.retry_limit) begin
                        r0.tx_byte = xcr_pkg::B_CAN;
                        st_in = xcr_pkg::ST_TMO; phase_in = xcr_pkg::PH_DONE;
                     end else begin
                        r0.tx_byte = first_ff ? xcr_pkg::B_NAK : xcr_pkg::B_C;
                     end
                  end
               end else if (wt >= cfg.char_timeout_ticks) begin
                  r0.tx_valid = 1'b1; r0.tx_byte = xcr_pkg::B_NAK; r0.block_verdict = sv;
                  wait_in = '0; idx_in = '0; phase_in = xcr_pkg::PH_HDR;
               end
            end
         end
         default: begin
            if (phase_ff != xcr_pkg::PH_IDLE && phase_ff != xcr_pkg::PH_DONE) begin
               r0.tx_valid = 1'b1; r0.tx_byte = xcr_pkg::B_CAN; r0.block_verdict = sv;
               two = 1'b1; r1.tx_valid = 1'b1; r1.tx_byte = xcr_pkg::B_CAN;
               st_in = xcr_pkg::ST_LCAN; phase_in = xcr_pkg::PH_DONE;
            end
         end
      endcase
      r0.session_status = st_in; r0.bytes_received = acc_in; r0.last = !two;
      r1.session_status = st_in; r1.bytes_received = acc_in; r1.last = 1'b1;

      slot0_in = slot0_ff; slot1_in = slot1_ff; cnt_in = cnt_ff;
      if (popped) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
      if (q_valid && q_take) begin
         slot0_in = r0; slot1_in = r1;
         cnt_in   = two ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xcr_pkg::PH_IDLE; first_ff <= 1'b0; retry_ff <= '0;
         exp_ff <= 8'd1; bno_ff <= '0; binv_ff <= '0; long_ff <= 1'b0;
         idx_ff <= '0; crc_ff <= '0; chi_ff <= '0; wait_ff <= '0;
         acc_ff <= '0; st_ff <= xcr_pkg::ST_IDLE; cnt_ff <= '0;
      end else begin
         if (q_valid && q_take) begin
            phase_ff <= phase_in; first_ff <= first_in; retry_ff <= retry_in;
            exp_ff <= exp_in; bno_ff <= bno_in; binv_ff <= binv_in;
            long_ff <= long_in; idx_ff <= idx_in; crc_ff <= crc_in;
            chi_ff <= chi_in; wait_ff <= wait_in; acc_ff <= acc_in; st_ff <= st_in;
         end
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("result buffer count invalid");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");
   assert property (@(posedge clock) disable iff (reset)
                    (cnt_ff == 2'd2) |-> !slot0_ff.last)
      else $error("first of two results marked last");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == xcr_pkg::PH_DATA) |-> long_ff || idx_ff <= ShortLast)
      else $error("short block index past end");
endmodule

// ===== rtl/core/xmodem_crc_receiver_top.sv =====
// Top level of the XMODEM-CRC receiver: configuration registers, front
// queue and protocol engine. Uses xcr_pkg, xcr_front and xcr_engine.
//
//   Channel | Direction | Ports                          | Transfer when
//   req     | in        | req_valid, req_stall, req_data | valid && !stall
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data | valid && !stall
//   csr     | in        | csr_write, csr_index, csr_data | write high
//
// One request item is taken per cycle while the result port does not stall; an
// item whose step yields two results (a NAK then 'C', or two CANs) holds the
// engine while the two-entry result buffer drains its first result, so each
// two-result item lowers the rate. Results are registered and appear in the
// cycle after the engine takes an item from the two-entry front queue. Reset
// is synchronous and leaves the session idle with the registers at their
// defaults. A stall on the result port holds the engine; the front queue keeps
// taking requests until it is full.
module xmodem_crc_receiver_top #(
   parameter int LongBlockBytes  = xcr_pkg::LongBlockBytes,
   parameter int ShortBlockBytes = xcr_pkg::ShortBlockBytes,
   parameter int QueueDepth      = xcr_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  xcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output xcr_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [16:0]      csr_data
);
   xcr_pkg::cfg_type cfg_ff, cfg_in;
   xcr_pkg::req_type q_data;
   logic q_valid, q_take;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            xcr_pkg::CSR_RETRY: cfg_in.retry_limit          = csr_data[7:0];
            xcr_pkg::CSR_HDR:   cfg_in.header_timeout_ticks = csr_data;
            xcr_pkg::CSR_CHAR:  cfg_in.char_timeout_ticks   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit          <= 8'd10;
         cfg_ff.header_timeout_ticks <= 17'd90000;
         cfg_ff.char_timeout_ticks   <= 17'd9000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   xcr_front #(.Depth(QueueDepth)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_take, .q_data
   );

   xcr_engine #(.LongBytes(LongBlockBytes), .ShortBytes(ShortBlockBytes)) u_engine (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_take, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the XMODEM-CRC receiver top level.
// Depends on xcr_pkg and xmodem_crc_receiver_top; drives framed blocks, ticks and cancels.
`timescale 1ns / 1ps

module testbench;

   localparam int WatchdogLimit = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   xcr_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   xcr_pkg::rsp_type rsp_data;
   logic             csr_write = 1'b0;
   logic [1:0]       csr_index = xcr_pkg::CSR_RETRY;
   logic [16:0]      csr_data = '0;

   xmodem_crc_receiver_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: a private copy of the receiver's session and registers.
   logic [7:0]  m_retry_limit;
   logic [16:0] m_hdr_ticks;
   logic [16:0] m_char_ticks;
   logic [2:0]  m_phase;
   logic        m_first_seen;
   logic [7:0]  m_retries;
   logic [7:0]  m_expected;
   logic [7:0]  m_blkno;
   logic [7:0]  m_blkinv;
   logic        m_long;
   logic [9:0]  m_index;
   logic [15:0] m_crc;
   logic [7:0]  m_crc_hi;
   logic [16:0] m_wait;
   logic [31:0] m_accepted;
   logic [2:0]  m_status;

   xcr_pkg::rsp_type expected_rsps[$];
   xcr_pkg::rsp_type step_rsps[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      finished = 1'b0;

   // Idle knobs: percentage of cycles in which each side holds back.
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   bit      hold_off = 1'b0;

   function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      return c;
   endfunction

   function automatic int unsigned block_bytes();
      return m_long ? xcr_pkg::LongBlockBytes : xcr_pkg::ShortBlockBytes;
   endfunction

   function automatic logic [1:0] pending_verdict();
      if ((m_phase == xcr_pkg::PH_DATA && m_index != '0) ||
          m_phase == xcr_pkg::PH_CHI || m_phase == xcr_pkg::PH_CLO)
         return xcr_pkg::VD_DISCARD;
      return xcr_pkg::VD_NONE;
   endfunction

   task automatic add_tx(input logic [7:0] b, input logic [1:0] vd);
      xcr_pkg::rsp_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = b;
      r.block_verdict = vd;
      if (step_rsps.size() < 2) step_rsps.push_back(r);
   endtask

   task automatic end_session(input logic [2:0] st);
      m_status = st;
      m_phase = xcr_pkg::PH_DONE;
   endtask

   task automatic predictor_reset();
      m_retry_limit = 8'd10; m_hdr_ticks = 17'd90000; m_char_ticks = 17'd9000;
      m_phase = xcr_pkg::PH_IDLE; m_first_seen = 0; m_retries = 0; m_expected = 8'd1;
      m_blkno = 0; m_blkinv = 0; m_long = 0; m_index = 0; m_crc = 0; m_crc_hi = 0;
      m_wait = 0; m_accepted = 0; m_status = xcr_pkg::ST_IDLE;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      xcr_pkg::rsp_type r;
      int unsigned len;
      m_wait = 0;
      case (m_phase)
         xcr_pkg::PH_HDR: begin
            m_retries = 0;
            if (b == xcr_pkg::B_EOT) begin
               add_tx(xcr_pkg::B_ACK, xcr_pkg::VD_NONE);
               end_session(xcr_pkg::ST_OK);
            end else if (b == xcr_pkg::B_CAN) begin
               end_session(xcr_pkg::ST_RCAN);
            end else if (b == xcr_pkg::B_SOH || b == xcr_pkg::B_STX) begin
               m_long = (b == xcr_pkg::B_STX);
               m_first_seen = 1'b1;
               m_phase = xcr_pkg::PH_BNO;
            end else begin
               add_tx(xcr_pkg::B_NAK, xcr_pkg::VD_NONE);
               if (!m_first_seen) add_tx(xcr_pkg::B_C, xcr_pkg::VD_NONE);
            end
         end
         xcr_pkg::PH_BNO: begin
            m_blkno = b;
            m_phase = xcr_pkg::PH_BINV;
         end
         xcr_pkg::PH_BINV: begin
            m_blkinv = b; m_index = 0; m_crc = 0;
            m_phase = xcr_pkg::PH_DATA;
         end
         xcr_pkg::PH_DATA: begin
            m_crc = crc_next(m_crc, b);
            r = '0;
            r.data_valid = 1'b1;
            r.data_byte = b;
            step_rsps.push_back(r);
            if (m_index + 1 >= block_bytes()) begin
               m_index = 0;
               m_phase = xcr_pkg::PH_CHI;
            end else begin
               m_index = m_index + 10'd1;
            end
         end
         xcr_pkg::PH_CHI: begin
            m_crc_hi = b;
            m_phase = xcr_pkg::PH_CLO;
         end
         xcr_pkg::PH_CLO: begin
            m_phase = xcr_pkg::PH_HDR;
            if (8'(m_blkno + m_blkinv) != 8'hFF || {m_crc_hi, b} != m_crc) begin
               add_tx(xcr_pkg::B_NAK, xcr_pkg::VD_DISCARD);
            end else if (m_blkno == m_expected) begin
               len = block_bytes();
               m_accepted = (m_accepted > 32'hFFFF_FFFF - len) ? 32'hFFFF_FFFF
                                                               : m_accepted + len;
               m_expected = m_expected + 8'd1;
               add_tx(xcr_pkg::B_ACK, xcr_pkg::VD_ACCEPT);
            end else if (m_blkno == m_expected - 8'd1) begin
               add_tx(xcr_pkg::B_ACK, xcr_pkg::VD_DISCARD);
            end else begin
               add_tx(xcr_pkg::B_CAN, xcr_pkg::VD_DISCARD);
               end_session(xcr_pkg::ST_ORDER);
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_tick();
      if (m_phase == xcr_pkg::PH_IDLE || m_phase == xcr_pkg::PH_DONE) return;
      if (m_wait != 17'h1FFFF) m_wait = m_wait + 17'd1;
      if (m_phase == xcr_pkg::PH_HDR) begin
         if (m_wait >= m_hdr_ticks) begin
            m_retries = m_retries + 8'd1;
            m_wait = 0;
            if (m_retries >= m_retry_limit) begin
               add_tx(xcr_pkg::B_CAN, xcr_pkg::VD_NONE);
               end_session(xcr_pkg::ST_TMO);
            end else begin
               add_tx(m_first_seen ? xcr_pkg::B_NAK : xcr_pkg::B_C, xcr_pkg::VD_NONE);
            end
         end
      end else if (m_wait >= m_char_ticks) begin
         add_tx(xcr_pkg::B_NAK, pending_verdict());
         m_wait = 0; m_index = 0;
         m_phase = xcr_pkg::PH_HDR;
      end
   endtask

   // Works out the results of one accepted request and queues them.
   task automatic predict_request(input xcr_pkg::req_type rq);
      logic [1:0] vd;
      step_rsps.delete();
      case (rq.op)
         xcr_pkg::OP_START: begin
            vd = pending_verdict();
            m_phase = xcr_pkg::PH_HDR; m_first_seen = 0; m_retries = 0; m_expected = 8'd1;
            m_index = 0; m_crc = 0; m_wait = 0; m_accepted = 0; m_status = xcr_pkg::ST_RUN;
            add_tx(xcr_pkg::B_C, vd);
         end
         xcr_pkg::OP_BYTE: predict_byte(rq.rx_byte);
         xcr_pkg::OP_TICK: predict_tick();
         default: begin
            if (m_phase != xcr_pkg::PH_IDLE && m_phase != xcr_pkg::PH_DONE) begin
               vd = pending_verdict();
               add_tx(xcr_pkg::B_CAN, vd);
               add_tx(xcr_pkg::B_CAN, xcr_pkg::VD_NONE);
               end_session(xcr_pkg::ST_LCAN);
            end
         end
      endcase
      if (step_rsps.size() == 0) step_rsps.push_back('0);
      foreach (step_rsps[k]) begin
         step_rsps[k].session_status = m_status;
         step_rsps[k].bytes_received = m_accepted;
         step_rsps[k].last = (k == step_rsps.size() - 1);
         expected_rsps.push_back(step_rsps[k]);
      end
   endtask

   // Result side: compare every transfer with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $realtime, rsp_data);
            errors++;
         end else begin
            if (rsp_data !== expected_rsps[0]) begin
               $display("%0t: result mismatch, expected %h, actual %h",
                        $realtime, expected_rsps[0], rsp_data);
               errors++;
            end
            void'(expected_rsps.pop_front());
         end
      end
   end

   // Receiver stall, randomized per cycle; a long hold-off overrides it.
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: counts cycles in which neither channel has a transfer, outside reset and hold-off.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || hold_off)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit && !finished) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Offers one request and waits for its transfer; the prediction is made at
   // the accepting edge so it sees the same order as the block does. Valid
   // stays high after the transfer until the next idle cycle or a drain.
   task automatic send_request(input logic [1:0] op, input logic [7:0] b);
      xcr_pkg::req_type rq;
      rq.op = op;
      rq.rx_byte = b;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (req_stall);
      predict_request(rq);
   endtask

   // Directed rows carry a check value only where it is obvious.
   task automatic send_checked(input logic [1:0] op, input logic [7:0] b,
                               input bit check_tx, input logic [7:0] tx_b,
                               input logic [2:0] st);
      send_request(op, b);
      if (check_tx && (step_rsps[0].tx_byte !== tx_b ||
                       step_rsps[0].session_status !== st)) begin
         $display("%0t: directed row mismatch, expected %h/%0d, actual %h/%0d", $realtime,
                  tx_b, st, step_rsps[0].tx_byte, step_rsps[0].session_status);
         errors++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [16:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         xcr_pkg::CSR_RETRY: m_retry_limit = val[7:0];
         xcr_pkg::CSR_HDR:   m_hdr_ticks = val;
         default:            m_char_ticks = val;
      endcase
      @(posedge clock);
   endtask

   // Sends one complete block, short or long as is_long selects.
   // The error choice corrupts the complement or the CRC.
   task automatic send_block(input bit is_long, input logic [7:0] num, input int err);
      logic [15:0] c;
      logic [7:0]  b;
      int          len;
      c = '0;
      len = is_long ? xcr_pkg::LongBlockBytes : xcr_pkg::ShortBlockBytes;
      send_request(xcr_pkg::OP_BYTE, is_long ? xcr_pkg::B_STX : xcr_pkg::B_SOH);
      send_request(xcr_pkg::OP_BYTE, num);
      send_request(xcr_pkg::OP_BYTE, (err == 1) ? num : ~num);
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(255));
         c = crc_next(c, b);
         send_request(xcr_pkg::OP_BYTE, b);
         if ($urandom_range(199) == 0) send_request(xcr_pkg::OP_TICK, 8'h00);
      end
      if (err == 2) c = c ^ 16'h0001;
      send_request(xcr_pkg::OP_BYTE, c[15:8]);
      send_request(xcr_pkg::OP_BYTE, c[7:0]);
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 70) send_request(xcr_pkg::OP_TICK, 8'($urandom_range(255)));
      else if (r < 88) send_request(xcr_pkg::OP_BYTE, 8'($urandom_range(255)));
      else if (r < 95) send_request(xcr_pkg::OP_START, 8'($urandom_range(255)));
      else send_request(xcr_pkg::OP_LCAN, 8'($urandom_range(255)));
   endtask

   // One random session: mostly well-formed blocks, some repeats, errors and noise.
   task automatic random_session(input int items_left);
      logic [7:0] num;
      int         r;
      num = 8'd1;
      send_request(xcr_pkg::OP_START, 8'($urandom_range(255)));
      while (items_left > 0) begin
         r = $urandom_range(99);
         if (r < 55) begin
            send_block(($urandom_range(15) == 0), num, 0);
            num = num + 8'd1;
         end else if (r < 62) begin
            send_block(1'b0, num - 8'd1, 0);
         end else if (r < 72) begin
            send_block(1'b0, num, $urandom_range(1, 2));
         end else if (r < 75) begin
            send_block(1'b0, 8'($urandom_range(255)), 0);
         end else begin
            repeat (3) random_item();
         end
         items_left = items_left - 1;
      end
      send_request(xcr_pkg::OP_BYTE, ($urandom_range(1)) ? xcr_pkg::B_EOT : xcr_pkg::B_CAN);
   endtask

   initial begin
      predictor_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: idle behavior, start, bad header, timeouts and all ops.
      send_checked(xcr_pkg::OP_BYTE,  8'hFF, 1, 8'h00, xcr_pkg::ST_IDLE);
      send_checked(xcr_pkg::OP_TICK,  8'h00, 1, 8'h00, xcr_pkg::ST_IDLE);
      send_checked(xcr_pkg::OP_LCAN,  8'h00, 1, 8'h00, xcr_pkg::ST_IDLE);
      send_checked(xcr_pkg::OP_START, 8'h00, 1, xcr_pkg::B_C,   xcr_pkg::ST_RUN);
      send_checked(xcr_pkg::OP_BYTE,  8'h00, 1, xcr_pkg::B_NAK, xcr_pkg::ST_RUN);
      send_checked(xcr_pkg::OP_BYTE,  8'hFF, 1, xcr_pkg::B_NAK, xcr_pkg::ST_RUN);
      drain();
      write_csr(xcr_pkg::CSR_RETRY, 17'd2);
      write_csr(xcr_pkg::CSR_HDR, 17'd1);
      write_csr(xcr_pkg::CSR_CHAR, 17'd1);
      send_checked(xcr_pkg::OP_TICK,  8'h00, 1, xcr_pkg::B_C,   xcr_pkg::ST_RUN);
      send_checked(xcr_pkg::OP_TICK,  8'h00, 1, xcr_pkg::B_CAN, xcr_pkg::ST_TMO);
      send_checked(xcr_pkg::OP_TICK,  8'h00, 1, 8'h00,          xcr_pkg::ST_TMO);
      send_checked(xcr_pkg::OP_START, 8'hFF, 1, xcr_pkg::B_C,   xcr_pkg::ST_RUN);
      send_request(xcr_pkg::OP_BYTE, xcr_pkg::B_SOH);
      send_request(xcr_pkg::OP_BYTE, 8'h01);
      send_request(xcr_pkg::OP_BYTE, 8'hFE);
      send_request(xcr_pkg::OP_BYTE, 8'hA5);
      send_request(xcr_pkg::OP_TICK, 8'h00);
      send_checked(xcr_pkg::OP_BYTE,  xcr_pkg::B_EOT, 1, xcr_pkg::B_ACK, xcr_pkg::ST_OK);
      send_checked(xcr_pkg::OP_START, 8'h00, 1, xcr_pkg::B_C,   xcr_pkg::ST_RUN);
      send_request(xcr_pkg::OP_BYTE, xcr_pkg::B_STX);
      send_request(xcr_pkg::OP_BYTE, 8'h00);
      send_request(xcr_pkg::OP_BYTE, 8'hFF);
      send_request(xcr_pkg::OP_BYTE, 8'h5A);
      send_checked(xcr_pkg::OP_LCAN,  8'h00, 1, xcr_pkg::B_CAN, xcr_pkg::ST_LCAN);
      send_checked(xcr_pkg::OP_START, 8'h00, 1, xcr_pkg::B_C,   xcr_pkg::ST_RUN);
      send_checked(xcr_pkg::OP_BYTE,  xcr_pkg::B_CAN, 1, 8'h00, xcr_pkg::ST_RCAN);
      drain();

      // Random phases over several register settings and idle patterns.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 84; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 84; end
            default: begin send_idle_pct = 23; recv_idle_pct = 23; end
         endcase
         write_csr(xcr_pkg::CSR_RETRY, (ph == 1) ? 17'd255 : 17'($urandom_range(1, 4)));
         write_csr(xcr_pkg::CSR_HDR, (ph == 2) ? 17'd131071 : 17'($urandom_range(1, 6)));
         write_csr(xcr_pkg::CSR_CHAR, (ph == 3) ? 17'd131071 : 17'($urandom_range(1, 8)));
         fork
            begin
               // Long receiver hold-off while requests keep coming in.
               if (ph == 0) begin
                  repeat (20) @(posedge clock);
                  hold_off = 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
            end
            begin
               random_session($urandom_range(1, 3));
               repeat (20) random_item();
            end
         join
         drain();
      end

      finished = 1'b1;
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/xcr_pkg.sv
rtl/core/xcr_front.sv
rtl/core/xcr_engine.sv
rtl/core/xmodem_crc_receiver_top.sv
tb/testbench.sv
